/* rtl/kbd_remap_pkg.sv */
// Shared types, modifier and usage constants, and the override table for the report remapper.
package kbd_remap_pkg;

   localparam int unsigned SlotCount = 6;
   localparam int unsigned RowCount  = 10;

   typedef logic [7:0] byte_type;
   typedef byte_type [SlotCount-1:0] slots_type;

   localparam byte_type MASK_LCTL   = 8'h01;
   localparam byte_type MASK_LSFT   = 8'h02;
   localparam byte_type MASK_LALT   = 8'h04;
   localparam byte_type MASK_LGUI   = 8'h08;
   localparam byte_type MASK_RCTL   = 8'h10;
   localparam byte_type MASK_RSFT   = 8'h20;
   localparam byte_type MASK_RGUI   = 8'h80;
   localparam byte_type MASK_HYPER  = MASK_LCTL | MASK_LSFT | MASK_LALT | MASK_LGUI;
   localparam byte_type MASK_ALL    = 8'hFF;
   localparam byte_type MASK_SHIFTS = MASK_LSFT | MASK_RSFT;
   localparam byte_type MASK_NONE   = 8'h00;

   localparam byte_type KEY_NONE  = 8'h00;
   localparam byte_type KEY_M     = 8'h10;
   localparam byte_type KEY_S     = 8'h16;
   localparam byte_type KEY_BSPC  = 8'h2A;
   localparam byte_type KEY_TAB   = 8'h2B;
   localparam byte_type KEY_HOME  = 8'h4A;
   localparam byte_type KEY_DEL   = 8'h4C;
   localparam byte_type KEY_END   = 8'h4D;
   localparam byte_type KEY_RIGHT = 8'h4F;
   localparam byte_type KEY_LEFT  = 8'h50;
   localparam byte_type KEY_F13   = 8'h68;
   localparam byte_type KEY_F21   = 8'h70;

   typedef struct packed {
      byte_type need;
      byte_type deny;
      byte_type key;
      byte_type put_mods;
      byte_type put_key;
   } row_type;

   // Rows are listed in priority order; the first hit wins.
   localparam row_type OverrideTable [RowCount] = '{
      '{MASK_LGUI, MASK_SHIFTS, KEY_LEFT,  MASK_LALT,  KEY_NONE},
      '{MASK_LGUI, MASK_SHIFTS, KEY_RIGHT, MASK_LALT,  KEY_NONE},
      '{MASK_LGUI, MASK_SHIFTS, KEY_BSPC,  MASK_LALT,  KEY_NONE},
      '{MASK_LGUI, MASK_SHIFTS, KEY_DEL,   MASK_LALT,  KEY_NONE},
      '{MASK_LGUI, MASK_NONE,   KEY_TAB,   MASK_LCTL,  KEY_NONE},
      '{MASK_LCTL, MASK_NONE,   KEY_TAB,   MASK_LGUI,  KEY_NONE},
      '{MASK_NONE, MASK_ALL,    KEY_HOME,  MASK_LGUI,  KEY_LEFT},
      '{MASK_NONE, MASK_ALL,    KEY_END,   MASK_LGUI,  KEY_RIGHT},
      '{MASK_NONE, MASK_ALL,    KEY_F13,   MASK_HYPER, KEY_M},
      '{MASK_NONE, MASK_ALL,    KEY_F21,   MASK_HYPER, KEY_S}
   };

   // Left Ctrl and left GUI trade places; right GUI also lands on left Ctrl.
   function automatic byte_type swap_mods(input byte_type m);
      byte_type r;
      r = m & ~(MASK_LCTL | MASK_LGUI | MASK_RGUI);
      if ((m & MASK_LCTL) != MASK_NONE) r = r | MASK_LGUI;
      if ((m & (MASK_LGUI | MASK_RGUI)) != MASK_NONE) r = r | MASK_LCTL;
      return r;
   endfunction

endpackage

/* rtl/keyboard_report_modifier_remap.sv */
// Top level of the keyboard report modifier remapper: input register, remap logic, result register.
//
// Usage:
//   An item is one keyboard report: a modifier byte and six key slots. It is
//   accepted at a rising edge with start high and busy low. busy never rises,
//   so a new item can be taken in every cycle.
//   Each result appears on the rsp_ ports for exactly one cycle, marked by
//   rsp_valid. An item sits in the input register after its accepting
//   edge, then passes the remap logic into the result register, which
//   drives the rsp_ ports. Results leave in acceptance order at one per
//   cycle; the receiver cannot stall.
//   The csr_ port writes mac_mode (bit 0 of csr_wdata) when csr_we is high.
//   With mac_mode low a report passes unchanged; with it high the modifier
//   swap and the ten-row override table are applied. Write it only while no
//   item is in flight.
//   Reset is synchronous and active high. It clears mac_mode and drops any
//   items in flight; no result appears for them.
module keyboard_report_modifier_remap (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  kbd_remap_pkg::byte_type req_modifiers_in,
   input  kbd_remap_pkg::byte_type req_key_in_0,
   input  kbd_remap_pkg::byte_type req_key_in_1,
   input  kbd_remap_pkg::byte_type req_key_in_2,
   input  kbd_remap_pkg::byte_type req_key_in_3,
   input  kbd_remap_pkg::byte_type req_key_in_4,
   input  kbd_remap_pkg::byte_type req_key_in_5,
   output logic                    rsp_valid,
   output kbd_remap_pkg::byte_type rsp_modifiers_out,
   output kbd_remap_pkg::byte_type rsp_key_out_0,
   output kbd_remap_pkg::byte_type rsp_key_out_1,
   output kbd_remap_pkg::byte_type rsp_key_out_2,
   output kbd_remap_pkg::byte_type rsp_key_out_3,
   output kbd_remap_pkg::byte_type rsp_key_out_4,
   output kbd_remap_pkg::byte_type rsp_key_out_5,
   input  logic                    csr_we,
   input  logic                    csr_wdata
);
   import kbd_remap_pkg::*;

   logic      mac_mode_ff;
   logic      in_valid_ff;
   logic      in_mode_ff;
   byte_type  in_mods_ff;
   slots_type in_keys_ff;
   logic      rsp_valid_ff;
   byte_type  rsp_mods_ff;
   slots_type rsp_keys_ff;

   byte_type           swapped;
   logic [RowCount-1:0] row_hit;
   byte_type           mods_in;
   slots_type          keys_in;
   logic [SlotCount-1:0] in_nz;
   logic [SlotCount-1:0] out_nz;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_mode_ff  <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mac_mode_ff <= csr_wdata;
         end
         in_valid_ff  <= start;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_mode_ff  <= mac_mode_ff;
      in_mods_ff  <= req_modifiers_in;
      in_keys_ff  <= {req_key_in_5, req_key_in_4, req_key_in_3,
                      req_key_in_2, req_key_in_1, req_key_in_0};
      rsp_mods_ff <= mods_in;
      rsp_keys_ff <= keys_in;
   end

   // Every row is tested in parallel against the swapped modifiers.
   always_comb begin
      logic present;
      swapped = swap_mods(in_mods_ff);
      for (int r = 0; r < RowCount; r++) begin
         present = 1'b0;
         for (int s = 0; s < SlotCount; s++) begin
            if (in_keys_ff[s] == OverrideTable[r].key) present = 1'b1;
         end
         row_hit[r] = present && (OverrideTable[r].key != KEY_NONE)
            && ((swapped & OverrideTable[r].need) == OverrideTable[r].need)
            && !((OverrideTable[r].deny != MASK_NONE)
                 && ((swapped & ~OverrideTable[r].need & OverrideTable[r].deny)
                     != MASK_NONE));
      end
   end

   // Only the highest-priority hit is applied.
   always_comb begin
      logic    found;
      logic    cleared;
      logic    placed;
      row_type sel;
      found   = 1'b0;
      cleared = 1'b0;
      placed  = 1'b0;
      sel     = OverrideTable[0];
      for (int r = 0; r < RowCount; r++) begin
         if (row_hit[r] && !found) begin
            found = 1'b1;
            sel   = OverrideTable[r];
         end
      end
      mods_in = in_mods_ff;
      keys_in = in_keys_ff;
      if (in_mode_ff) begin
         mods_in = swapped;
         if (found) begin
            mods_in = (swapped & ~sel.need) | sel.put_mods;
            if (sel.put_key != KEY_NONE) begin
               for (int s = 0; s < SlotCount; s++) begin
                  if (!cleared && keys_in[s] == sel.key) begin
                     keys_in[s] = KEY_NONE;
                     cleared    = 1'b1;
                  end
               end
               for (int s = 0; s < SlotCount; s++) begin
                  if (!placed && keys_in[s] == KEY_NONE) begin
                     keys_in[s] = sel.put_key;
                     placed     = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_modifiers_out = rsp_mods_ff;
   assign rsp_key_out_0     = rsp_keys_ff[0];
   assign rsp_key_out_1     = rsp_keys_ff[1];
   assign rsp_key_out_2     = rsp_keys_ff[2];
   assign rsp_key_out_3     = rsp_keys_ff[3];
   assign rsp_key_out_4     = rsp_keys_ff[4];
   assign rsp_key_out_5     = rsp_keys_ff[5];

   always_comb begin
      for (int s = 0; s < SlotCount; s++) begin
         in_nz[s]  = in_keys_ff[s] != KEY_NONE;
         out_nz[s] = rsp_keys_ff[s] != KEY_NONE;
      end
   end

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> rsp_valid)
      else $error("accepted item produced no result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result without an accepted item");

   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_mode_ff) |=>
         (rsp_modifiers_out == $past(in_mods_ff)) && (rsp_keys_ff == $past(in_keys_ff)))
      else $error("report changed with remapping off");

   a_key_count_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> $countones(out_nz) == $past($countones(in_nz)))
      else $error("number of occupied key slots changed");

endmodule

/* tb/sv/keyboard_report_remap_checker.sv */
// Checker for the report remapper: predicts each remapped report and compares the results.
`timescale 1ns / 1ps

module keyboard_report_remap_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  kbd_remap_pkg::byte_type  req_modifiers_in,
   input  kbd_remap_pkg::slots_type req_keys,
   input  logic                     rsp_valid,
   input  kbd_remap_pkg::byte_type  rsp_modifiers_out,
   input  kbd_remap_pkg::slots_type rsp_keys,
   input  logic                     csr_we,
   input  logic                     csr_wdata,
   output int                       failures,
   output int                       pending
);
   import kbd_remap_pkg::*;

   typedef struct packed {
      byte_type  mods;
      slots_type keys;
   } report_type;

   typedef struct packed {
      byte_type need;
      byte_type deny;
      byte_type key;
      byte_type new_mods;
      byte_type new_key;
   } shortcut_type;

   report_type expected_reports [$];
   logic       mode_copy    = 1'b0;
   int         error_count  = 0;
   int         result_index = 0;

   // The override rows in priority order.
   function automatic shortcut_type shortcut_row(input int n);
      shortcut_type s;
      case (n)
         0: s = '{MASK_LGUI, MASK_SHIFTS, KEY_LEFT,  MASK_LALT,  KEY_NONE};
         1: s = '{MASK_LGUI, MASK_SHIFTS, KEY_RIGHT, MASK_LALT,  KEY_NONE};
         2: s = '{MASK_LGUI, MASK_SHIFTS, KEY_BSPC,  MASK_LALT,  KEY_NONE};
         3: s = '{MASK_LGUI, MASK_SHIFTS, KEY_DEL,   MASK_LALT,  KEY_NONE};
         4: s = '{MASK_LGUI, MASK_NONE,   KEY_TAB,   MASK_LCTL,  KEY_NONE};
         5: s = '{MASK_LCTL, MASK_NONE,   KEY_TAB,   MASK_LGUI,  KEY_NONE};
         6: s = '{MASK_NONE, MASK_ALL,    KEY_HOME,  MASK_LGUI,  KEY_LEFT};
         7: s = '{MASK_NONE, MASK_ALL,    KEY_END,   MASK_LGUI,  KEY_RIGHT};
         8: s = '{MASK_NONE, MASK_ALL,    KEY_F13,   MASK_HYPER, KEY_M};
         default: s = '{MASK_NONE, MASK_ALL, KEY_F21, MASK_HYPER, KEY_S};
      endcase
      return s;
   endfunction

   function automatic report_type remap_report(input logic mode, input report_type rin);
      report_type   r;
      shortcut_type s;
      byte_type     m;
      logic         hit;
      logic         present;
      logic         done;
      r   = rin;
      hit = 1'b0;
      if (mode) begin
         m = rin.mods;
         r.mods = (m & ~(MASK_LCTL | MASK_LGUI | MASK_RGUI))
                | (((m & MASK_LCTL) != MASK_NONE) ? MASK_LGUI : MASK_NONE)
                | (((m & (MASK_LGUI | MASK_RGUI)) != MASK_NONE) ? MASK_LCTL : MASK_NONE);
         for (int row = 0; row < RowCount; row++) begin
            s = shortcut_row(row);
            present = 1'b0;
            for (int i = 0; i < SlotCount; i++)
               if (s.key != KEY_NONE && r.keys[i] == s.key) present = 1'b1;
            if (!hit && present && (r.mods & s.need) == s.need
                && (r.mods & ~s.need & s.deny) == MASK_NONE) begin
               hit = 1'b1;
               r.mods = (r.mods & ~s.need) | s.new_mods;
               if (s.new_key != KEY_NONE) begin
                  // Only the first copy of the matched key goes away.
                  done = 1'b0;
                  for (int i = 0; i < SlotCount; i++)
                     if (!done && r.keys[i] == s.key) begin
                        r.keys[i] = KEY_NONE;
                        done = 1'b1;
                     end
                  done = 1'b0;
                  for (int i = 0; i < SlotCount; i++)
                     if (!done && r.keys[i] == KEY_NONE) begin
                        r.keys[i] = s.new_key;
                        done = 1'b1;
                     end
               end
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input byte_type got, input byte_type want);
      $display("result %0d: %s is %02h, expected %02h", result_index, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         mode_copy = 1'b0;
         expected_reports.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               $display("result %0d arrived with no item waiting for it", result_index);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_modifiers_out !== want.mods)
                  report_mismatch("modifiers", rsp_modifiers_out, want.mods);
               for (int i = 0; i < SlotCount; i++)
                  if (rsp_keys[i] !== want.keys[i])
                     report_mismatch($sformatf("key slot %0d", i), rsp_keys[i], want.keys[i]);
            end
            result_index++;
         end
         if (start && !busy)
            expected_reports.push_back(remap_report(mode_copy, {req_modifiers_in, req_keys}));
         if (csr_we) mode_copy = csr_wdata;
      end
      failures <= error_count;
      pending  <= expected_reports.size();
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the report remapper testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
   import kbd_remap_pkg::*;

   localparam int CycleLimit = 100000;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   byte_type  req_mods;
   slots_type req_keys;
   logic      rsp_valid;
   byte_type  rsp_mods;
   slots_type rsp_keys;
   logic      csr_we;
   logic      csr_wdata;
   int        failures;
   int        pending;
   int        cycles = 0;

   keyboard_report_modifier_remap dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_modifiers_in  (req_mods),
      .req_key_in_0      (req_keys[0]),
      .req_key_in_1      (req_keys[1]),
      .req_key_in_2      (req_keys[2]),
      .req_key_in_3      (req_keys[3]),
      .req_key_in_4      (req_keys[4]),
      .req_key_in_5      (req_keys[5]),
      .rsp_valid         (rsp_valid),
      .rsp_modifiers_out (rsp_mods),
      .rsp_key_out_0     (rsp_keys[0]),
      .rsp_key_out_1     (rsp_keys[1]),
      .rsp_key_out_2     (rsp_keys[2]),
      .rsp_key_out_3     (rsp_keys[3]),
      .rsp_key_out_4     (rsp_keys[4]),
      .rsp_key_out_5     (rsp_keys[5]),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   keyboard_report_remap_checker remap_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_modifiers_in  (req_mods),
      .req_keys          (req_keys),
      .rsp_valid         (rsp_valid),
      .rsp_modifiers_out (rsp_mods),
      .rsp_keys          (rsp_keys),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .failures          (failures),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic byte_type trigger_key(input int n);
      case (n)
         0: return KEY_LEFT;
         1: return KEY_RIGHT;
         2: return KEY_BSPC;
         3: return KEY_DEL;
         4: return KEY_TAB;
         5: return KEY_HOME;
         6: return KEY_END;
         7: return KEY_F13;
         default: return KEY_F21;
      endcase
   endfunction

   // Most reports carry a key from the override table and a modifier set
   // close to what a row wants; the rest are plain noise.
   function automatic void pick_report(output byte_type mods, output slots_type keys);
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < SlotCount; i++)
         case ($urandom_range(0, 3))
            0: keys[i] = KEY_NONE;
            1: keys[i] = trigger_key($urandom_range(0, 8));
            default: keys[i] = byte_type'($urandom);
         endcase
      if (kind < 6) begin
         keys[$urandom_range(0, SlotCount - 1)] = trigger_key($urandom_range(0, 8));
         case ($urandom_range(0, 4))
            0: mods = MASK_NONE;
            1: mods = byte_type'(1 << $urandom_range(0, 7));
            2: mods = MASK_LCTL;
            3: mods = (($urandom_range(0, 1) != 0) ? MASK_LGUI : MASK_RGUI)
                    | byte_type'(1 << $urandom_range(0, 7));
            default: mods = byte_type'($urandom);
         endcase
      end else begin
         mods = byte_type'($urandom);
         if (kind == 9) keys = slots_type'({$urandom, $urandom});
      end
   endfunction

   // Leaves start high; the caller lowers it only when a gap follows.
   task automatic send_report(input byte_type mods, input slots_type keys);
      start    <= 1'b1;
      req_mods <= mods;
      req_keys <= keys;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pause_sender(input int n);
      start    <= 1'b0;
      req_mods <= byte_type'($urandom);
      req_keys <= slots_type'({$urandom, $urandom});
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic value);
      wait_all_results();
      // Results are registered after acceptance; leave room for them.
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_phase(input logic mode, input int count, input bit quiet_tail);
      byte_type  mods;
      slots_type keys;
      write_mode(mode);
      for (int n = 0; n < count; n++) begin
         pick_report(mods, keys);
         send_report(mods, keys);
         if (n == count / 3) wait_all_results();
         else if (!(quiet_tail && n >= count - 100) && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 15));
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_mods  <= MASK_NONE;
      req_keys  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Pass-through after reset. Slot 0 is the rightmost byte in each list.
      send_report(MASK_ALL, {6{8'hFF}});
      send_report(MASK_LCTL, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_HOME, KEY_LEFT});

      write_mode(1'b1);
      send_report(MASK_NONE, {6{KEY_NONE}});
      send_report(MASK_ALL, {6{8'hFF}});
      // Left Ctrl swaps to left GUI, so the arrow and edit rows fire.
      send_report(MASK_LCTL, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_LEFT});
      send_report(MASK_LCTL, {KEY_NONE, KEY_NONE, KEY_RIGHT, KEY_NONE, KEY_NONE, 8'h04});
      send_report(MASK_LCTL, {8'h05, KEY_BSPC, 8'h06, 8'h07, 8'h08, 8'h09});
      send_report(MASK_LCTL | MASK_LALT,
                  {KEY_DEL, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, 8'hFF});
      // Either shift blocks the arrow rows.
      send_report(MASK_LCTL | MASK_LSFT,
                  {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_LEFT});
      send_report(MASK_LCTL | MASK_RSFT,
                  {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_RIGHT});
      // Right GUI lands on left Ctrl; tab rows in both directions.
      send_report(MASK_RGUI, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_TAB});
      send_report(MASK_LGUI, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_TAB});
      send_report(MASK_LCTL, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_TAB});
      send_report(MASK_LCTL | MASK_LGUI | MASK_LSFT, {KEY_TAB, KEY_NONE, KEY_NONE, KEY_NONE,
                                                       KEY_NONE, KEY_NONE});
      // Two rows present: the earlier one wins.
      send_report(MASK_LCTL, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_TAB, KEY_LEFT});
      // Key rows with the new key placed in the lowest empty slot.
      send_report(MASK_NONE, {8'h08, 8'h07, 8'h06, KEY_HOME, KEY_NONE, 8'h04});
      send_report(MASK_NONE, {8'h08, 8'h07, 8'h06, 8'h05, KEY_HOME, KEY_HOME});
      send_report(MASK_NONE, {KEY_END, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03});
      send_report(MASK_NONE, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_F13, KEY_NONE});
      send_report(MASK_NONE, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, KEY_F21});
      // Any modifier at all blocks the key rows.
      send_report(MASK_RSFT, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_HOME});
      send_report(MASK_RCTL, {KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_F13});

      random_phase(1'b1, 300, 1'b0);
      random_phase(1'b0, 150, 1'b0);
      random_phase(1'b1, 300, 1'b1);

      wait_all_results();
      repeat (5) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
